@@ hdl/assert_macros.svh @@
// assertion macros shared by the random source modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define XRS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define XRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/xrs_pkg.sv @@
// shared types, constants and helpers for the xorshift32 random source
package xrs_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned CntW  = 5;

  localparam logic [WordW-1:0] GEN_RESET_WORD = 32'hDEAD_BEEF;
  localparam int unsigned      SHIFT_A        = 13;
  localparam int unsigned      SHIFT_B        = 17;
  localparam int unsigned      SHIFT_C        = 5;

  // request codes
  localparam logic [1:0] REQ_INT  = 2'd0;
  localparam logic [1:0] REQ_BOOL = 2'd1;
  localparam logic [1:0] REQ_FRAC = 2'd2;

  localparam logic [CntW-1:0] LAST_STEP = 5'd31;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_WAIT_OUT
  } xrs_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture a request; advance the generator for bool, fraction and positive-bound integer requests
    logic step;   // one restoring division step
    logic push;   // move the work result into the output register
  } xrs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_div;    // pending input needs the divider
    logic div_done;  // current step is the last one
    logic out_free;  // output register can take a result
  } xrs_sts_t;

  function automatic logic [WordW-1:0] xs_next(input logic [WordW-1:0] x);
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    a = x ^ (x << SHIFT_A);
    b = a ^ (a >> SHIFT_B);
    return b ^ (b << SHIFT_C);
  endfunction

endpackage

@@ hdl/xorshift32_random_source.sv @@
// top level of the xorshift32 random source
// bool, fraction, unused code, bound <= 0: capture, then output load once the output register is free
// integer requests with a positive bound: capture, 32 remainder steps, then output load once it is free
// throughput: one request at a time, for integer requests set by the one-bit-per-cycle remainder unit
// the output register frees the input side while a result waits for its transfer
// reset: generator word goes to 0xDEADBEEF, controller idle, no result pending
module xorshift32_random_source import xrs_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // request channel
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              req_type_i,
  input  logic signed [WordW-1:0] upper_bound_i,
  // result channel
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [WordW-1:0]        result_value_o,
  // seed register write channel
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [WordW-1:0]        seed_value_i
);

  xrs_cmd_t cmd;
  xrs_sts_t sts;
  logic     seed_we;

  // seed writes land in the generator word (a zero seed becomes 1), always taken
  assign cfg_ready_o = 1'b1;
  assign seed_we     = cfg_valid_i && cfg_ready_o;

  // sequencer: capture, divide, hand off to the output register
  xrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // generator word, remainder unit, output register
  xrs_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .req_type_i     (req_type_i),
    .upper_bound_i  (upper_bound_i),
    .seed_we_i      (seed_we),
    .seed_value_i   (seed_value_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .result_value_o (result_value_o)
  );

endmodule

@@ hdl/xrs_datapath.sv @@
// generator word, iterative remainder unit and output register
`include "assert_macros.svh"

module xrs_datapath import xrs_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  xrs_cmd_t                cmd_i,
  output xrs_sts_t                sts_o,
  input  logic [1:0]              req_type_i,
  input  logic signed [WordW-1:0] upper_bound_i,
  input  logic                    seed_we_i,
  input  logic [WordW-1:0]        seed_value_i,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic [WordW-1:0]        result_value_o
);

  logic [WordW-1:0] state_q, state_d;
  logic [WordW-1:0] rem_q, rem_d;
  logic [WordW-1:0] dvd_q, dvd_d;
  logic [WordW-2:0] dvs_q, dvs_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [WordW-1:0] out_q, out_d;
  logic             out_valid_q, out_valid_d;

  logic [WordW-1:0] next_word;
  logic             bound_pos;
  logic [WordW-1:0] trial;

  assign next_word = xs_next(state_q);
  assign bound_pos = !upper_bound_i[WordW-1] && (upper_bound_i != '0);
  assign trial     = {rem_q[WordW-2:0], dvd_q[WordW-1]};

  assign sts_o.is_div   = (req_type_i == REQ_INT) && bound_pos;
  assign sts_o.div_done = (cnt_q == LAST_STEP);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    dvd_d       = dvd_q;
    dvs_d       = dvs_q;
    cnt_d       = cnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;

    if (cmd_i.load) begin
      rem_d = '0;
      case (req_type_i)
        REQ_INT: begin
          if (bound_pos) begin
            state_d = next_word;
            dvd_d   = next_word;
            dvs_d   = upper_bound_i[WordW-2:0];
            cnt_d   = '0;
          end
        end
        REQ_BOOL: begin
          state_d = next_word;
          rem_d   = {{(WordW-1){1'b0}}, next_word[0]};
        end
        REQ_FRAC: begin
          state_d = next_word;
          rem_d   = next_word;
        end
        default: rem_d = '0;
      endcase
    end

    if (cmd_i.step) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = trial - {1'b0, dvs_q};
      end else begin
        rem_d = trial;
      end
      dvd_d = {dvd_q[WordW-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
    end

    if (seed_we_i) begin
      state_d = (seed_value_i == '0) ? {{(WordW-1){1'b0}}, 1'b1} : seed_value_i;
    end

    if (cmd_i.push) begin
      out_d       = rem_q;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= GEN_RESET_WORD;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    cnt_q <= cnt_d;
    out_q <= out_d;
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_q;

  `XRS_ASSERT(a_state_nonzero, state_q != '0, "generator word reached zero")
  `XRS_ASSERT_NEXT(a_push_sets_valid, cmd_i.push, out_valid_q, "pushed result not presented")

endmodule

@@ hdl/xrs_ctrl.sv @@
// request sequencer for the random source
`include "assert_macros.svh"

module xrs_ctrl import xrs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  xrs_sts_t sts_i,
  output xrs_cmd_t cmd_o
);

  xrs_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.is_div ? ST_DIVIDE : ST_WAIT_OUT;
        end
      end
      ST_DIVIDE: begin
        cmd_o.step = 1'b1;
        if (sts_i.div_done) begin
          state_d = ST_WAIT_OUT;
        end
      end
      ST_WAIT_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  `XRS_ASSERT(a_push_when_free, !cmd_o.push || sts_i.out_free, "result pushed over pending one")
  `XRS_ASSERT_NEXT(a_load_leaves_idle, cmd_o.load, state_q != ST_IDLE, "load did not start work")
  `XRS_ASSERT_NEXT(a_div_finishes, cmd_o.step && sts_i.div_done, state_q == ST_WAIT_OUT,
                   "division end missed")
  `XRS_ASSERT(a_one_cmd, $onehot0({cmd_o.load, cmd_o.step, cmd_o.push}), "overlapping commands")

endmodule
